// ----- hw/rtl/stpramp_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the stepper ramp generator.
package stpramp_pkg;

   localparam int DELAY_BITS   = 16;
   localparam int COUNT_BITS   = 24;
   localparam int RAMP_BITS    = 16;
   localparam int ACTION_BITS  = 3;
   localparam int CMP_BITS     = (COUNT_BITS > RAMP_BITS + 1) ? COUNT_BITS : RAMP_BITS + 1;
   localparam int NXT_BITS     = DELAY_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(DELAY_BITS);

   localparam int REQ_FIELD_BITS = ACTION_BITS + DELAY_BITS + COUNT_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DELAY_BITS-1:0] BASE_DELAY_RST  = DELAY_BITS'(1000);
   localparam logic [RAMP_BITS-1:0]  RAMP_PULSES_RST = RAMP_BITS'(200);

   // register indexes
   localparam logic REG_BASE_DELAY  = 1'b0;
   localparam logic REG_RAMP_PULSES = 1'b1;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FWD   = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_BWD   = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_LEFT  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_RIGHT = 3'd4;

   // direction pins {left, right}
   localparam logic [1:0] DIR_FWD   = 2'b10;
   localparam logic [1:0] DIR_BWD   = 2'b01;
   localparam logic [1:0] DIR_LEFT  = 2'b00;
   localparam logic [1:0] DIR_RIGHT = 2'b11;

   // segment indexes
   localparam logic [1:0] SEG_ACCEL  = 2'd0;
   localparam logic [1:0] SEG_CRUISE = 2'd1;
   localparam logic [1:0] SEG_DECEL  = 2'd2;

   typedef struct packed {
      logic tick;        // tick taken while a move runs
      logic start_move;  // latch a move command, seed the divider
      logic div_step;    // one quotient bit
      logic load_first;  // load accel segment, arm first tick
      logic load_next;   // advance to next segment
      logic pulse;       // emit a step, advance the delay
      logic finish;      // end the move
   } dp_cmd_type;

   typedef struct packed {
      logic       moving;
      logic       tick_due;   // countdown reaches zero on this tick
      logic       seg_empty;
      logic       last_seg;
      logic       div_last;
      logic [1:0] dir;        // {left, right}
   } dp_stat_type;

endpackage

// ----- hw/rtl/stepper_trapezoid_ramp_generator_unit.sv -----
// Top level of the two-wheel stepper trapezoid ramp generator.
//
//  Channel   Ports               Direction   Carries
//  --------  ------------------  ----------  -----------------------------------------
//  request   req_t*              in          tick or move command, one per transfer
//  response  rsp_t*              out         step/dir/busy/done/rejected, one per request
//  config    csr_p*              in/out      base_delay (0x0), ramp_pulses (0x4)
//
// Sequencing: a tick is accepted and then its result is registered; a tick on
// which an event falls due first visits the event state, which repeats for
// each empty segment skipped. A move command runs through the divide, load and
// result states: the per-move step size comes out of a restoring divider giving
// one quotient bit per cycle. A rejected command goes straight to result.
// Reset: synchronous, active high; idle, direction pins forward, registers at
// their defaults. No clearing pass.
// Stalls: the result register holds while rsp_tready is low; the next request
// is taken meanwhile and its result waits until the register frees up.
module stepper_trapezoid_ramp_generator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: [2:0] action, [18:3] target_delay, [42:19] pulse_count, rest zero
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [stpramp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // response: [0] step, [1] right_dir, [2] left_dir, [3] busy_res,
   //           [4] done_res, [5] rejected, [7:6] zero
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [stpramp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // configuration
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [stpramp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [stpramp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [stpramp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   localparam int AB = stpramp_pkg::ACTION_BITS;
   localparam int DB = stpramp_pkg::DELAY_BITS;
   localparam int CB = stpramp_pkg::COUNT_BITS;

   logic [AB-1:0]                     action;
   logic [DB-1:0]                     target_delay;
   logic [CB-1:0]                     pulse_count;
   logic [DB-1:0]                     base_delay;
   logic [stpramp_pkg::RAMP_BITS-1:0] ramp_pulses;
   stpramp_pkg::dp_cmd_type           cmd;
   stpramp_pkg::dp_stat_type          stat;

   // unpack request fields
   assign action       = req_tdata[AB-1:0];
   assign target_delay = req_tdata[AB+DB-1:AB];
   assign pulse_count  = req_tdata[AB+DB+CB-1:AB+DB];

   stpramp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .base_delay  (base_delay),
      .ramp_pulses (ramp_pulses)
   );

   stpramp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (action),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   stpramp_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .action       (action),
      .target_delay (target_delay),
      .pulse_count  (pulse_count),
      .base_delay   (base_delay),
      .ramp_pulses  (ramp_pulses)
   );

endmodule

// ----- hw/rtl/stpramp_csr.sv -----
// APB-style register file: base_delay and ramp_pulses.
module stpramp_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [stpramp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [stpramp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [stpramp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output logic [stpramp_pkg::DELAY_BITS-1:0]     base_delay,
   output logic [stpramp_pkg::RAMP_BITS-1:0]      ramp_pulses
);

   logic [stpramp_pkg::DELAY_BITS-1:0] base_delay_ff, base_delay_in;
   logic [stpramp_pkg::RAMP_BITS-1:0]  ramp_pulses_ff, ramp_pulses_in;
   logic                               wr_en;
   logic                               reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      base_delay_in  = base_delay_ff;
      ramp_pulses_in = ramp_pulses_ff;
      if (wr_en) begin
         case (reg_sel)
            stpramp_pkg::REG_BASE_DELAY: begin
               base_delay_in = csr_pwdata[stpramp_pkg::DELAY_BITS-1:0];
            end
            stpramp_pkg::REG_RAMP_PULSES: begin
               ramp_pulses_in = csr_pwdata[stpramp_pkg::RAMP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         stpramp_pkg::REG_BASE_DELAY: begin
            csr_prdata = stpramp_pkg::CSR_DATA_BITS'(base_delay_ff);
         end
         stpramp_pkg::REG_RAMP_PULSES: begin
            csr_prdata = stpramp_pkg::CSR_DATA_BITS'(ramp_pulses_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff  <= stpramp_pkg::BASE_DELAY_RST;
         ramp_pulses_ff <= stpramp_pkg::RAMP_PULSES_RST;
      end else begin
         base_delay_ff  <= base_delay_in;
         ramp_pulses_ff <= ramp_pulses_in;
      end
   end

   assign base_delay  = base_delay_ff;
   assign ramp_pulses = ramp_pulses_ff;

endmodule

// ----- hw/rtl/stpramp_dpath.sv -----
// Move datapath: segment state, delay stepping, tick countdown and serial divider.
module stpramp_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stpramp_pkg::dp_cmd_type               cmd,
   output stpramp_pkg::dp_stat_type              stat,
   input  logic [stpramp_pkg::ACTION_BITS-1:0]   action,
   input  logic [stpramp_pkg::DELAY_BITS-1:0]    target_delay,
   input  logic [stpramp_pkg::COUNT_BITS-1:0]    pulse_count,
   input  logic [stpramp_pkg::DELAY_BITS-1:0]    base_delay,
   input  logic [stpramp_pkg::RAMP_BITS-1:0]     ramp_pulses
);

   localparam int DB = stpramp_pkg::DELAY_BITS;
   localparam int CB = stpramp_pkg::COUNT_BITS;
   localparam int RB = stpramp_pkg::RAMP_BITS;
   localparam int MB = stpramp_pkg::CMP_BITS;
   localparam int NB = stpramp_pkg::NXT_BITS;
   localparam int KB = stpramp_pkg::DIV_CNT_BITS;

   // control state
   logic          moving_ff, moving_in;
   logic [1:0]    dir_ff, dir_in;
   logic [1:0]    seg_idx_ff, seg_idx_in;
   // payload state
   logic [CB-1:0] pulses_left_ff, pulses_left_in;
   logic [DB-1:0] start_ff, start_in;
   logic [DB-1:0] end_ff, end_in;
   logic [DB-1:0] cur_ff, cur_in;
   logic [DB-1:0] step_mag_ff, step_mag_in;
   logic          step_neg_ff, step_neg_in;
   logic          ramping_ff, ramping_in;
   logic [DB-1:0] cd_ff, cd_in;
   logic [DB-1:0] cruise_ff, cruise_in;
   logic [DB-1:0] idle_lat_ff, idle_lat_in;
   logic [RB-1:0] ramp_len_ff, ramp_len_in;
   logic [CB-1:0] cruise_len_ff, cruise_len_in;
   logic [DB-1:0] mag0_ff, mag0_in;
   logic [DB-1:0] quo_ff, quo_in;
   logic [RB-1:0] rem_ff, rem_in;
   logic [KB-1:0] div_cnt_ff, div_cnt_in;

   // command decode helpers
   logic [MB-1:0] pls_ext, twice_ext, cruise_len_ext;
   logic          short_move;
   logic [RB:0]   trial;
   logic          trial_ge;
   logic [RB:0]   trial_sub;
   logic [1:0]    load_k;
   logic          do_load;
   logic signed [NB-1:0] cur_s, mag_s, nxt_s, lo_s, hi_s;
   logic          nxt_out;

   assign pls_ext        = MB'(pulse_count);
   assign twice_ext      = MB'({ramp_pulses, 1'b0});
   assign short_move     = pls_ext < twice_ext;
   assign cruise_len_ext = pls_ext - twice_ext;

   assign trial     = {rem_ff, quo_ff[DB-1]};
   assign trial_ge  = trial >= {1'b0, ramp_len_ff};
   assign trial_sub = trial - {1'b0, ramp_len_ff};

   assign do_load = cmd.load_first | cmd.load_next;
   assign load_k  = cmd.load_first ? stpramp_pkg::SEG_ACCEL : 2'(seg_idx_ff + 2'd1);

   assign cur_s   = signed'(NB'(cur_ff));
   assign mag_s   = signed'(NB'(step_mag_ff));
   assign nxt_s   = step_neg_ff ? (cur_s + mag_s) : (cur_s - mag_s);
   assign lo_s    = (start_ff <= end_ff) ? signed'(NB'(start_ff)) : signed'(NB'(end_ff));
   assign hi_s    = (start_ff <= end_ff) ? signed'(NB'(end_ff)) : signed'(NB'(start_ff));
   assign nxt_out = (nxt_s < lo_s) || (nxt_s > hi_s);

   always_comb begin
      moving_in      = moving_ff;
      dir_in         = dir_ff;
      seg_idx_in     = seg_idx_ff;
      pulses_left_in = pulses_left_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      cur_in         = cur_ff;
      step_mag_in    = step_mag_ff;
      step_neg_in    = step_neg_ff;
      ramping_in     = ramping_ff;
      cd_in          = cd_ff;
      cruise_in      = cruise_ff;
      idle_lat_in    = idle_lat_ff;
      ramp_len_in    = ramp_len_ff;
      cruise_len_in  = cruise_len_ff;
      mag0_in        = mag0_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;

      if (cmd.start_move) begin
         case (action)
            stpramp_pkg::ACT_BWD:   dir_in = stpramp_pkg::DIR_BWD;
            stpramp_pkg::ACT_LEFT:  dir_in = stpramp_pkg::DIR_LEFT;
            stpramp_pkg::ACT_RIGHT: dir_in = stpramp_pkg::DIR_RIGHT;
            default:                dir_in = stpramp_pkg::DIR_FWD;
         endcase
         cruise_in   = target_delay;
         idle_lat_in = base_delay;
         if (short_move) begin
            ramp_len_in   = RB'(pls_ext >> 1);
            cruise_len_in = '0;
         end else begin
            ramp_len_in   = ramp_pulses;
            cruise_len_in = CB'(cruise_len_ext);
         end
         // divider seeded with |idle - cruise|
         quo_in     = (base_delay >= target_delay) ? (base_delay - target_delay)
                                                   : (target_delay - base_delay);
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         quo_in     = {quo_ff[DB-2:0], trial_ge};
         rem_in     = trial_ge ? RB'(trial_sub) : RB'(trial);
         div_cnt_in = KB'(div_cnt_ff + KB'(1));
      end

      if (cmd.load_first) begin
         // zero divisor or zero quotient falls back to a unit step
         mag0_in   = (quo_ff == '0 || ramp_len_ff == '0) ? DB'(1) : quo_ff;
         cd_in     = DB'(1);
         moving_in = 1'b1;
      end

      if (do_load) begin
         seg_idx_in     = load_k;
         pulses_left_in = (load_k == stpramp_pkg::SEG_CRUISE) ? cruise_len_ff
                                                               : CB'(ramp_len_ff);
         start_in       = (load_k == stpramp_pkg::SEG_ACCEL) ? idle_lat_ff : cruise_ff;
         end_in         = (load_k == stpramp_pkg::SEG_DECEL) ? idle_lat_ff : cruise_ff;
         cur_in         = start_in;
         ramping_in     = 1'b1;
         case (load_k)
            stpramp_pkg::SEG_ACCEL: begin
               step_neg_in = idle_lat_ff < cruise_ff;
               step_mag_in = (quo_ff == '0 || ramp_len_ff == '0) ? DB'(1) : quo_ff;
            end
            stpramp_pkg::SEG_DECEL: begin
               step_neg_in = cruise_ff < idle_lat_ff;
               step_mag_in = mag0_ff;
            end
            default: begin
               step_neg_in = 1'b0;
               step_mag_in = DB'(1);
            end
         endcase
      end

      if (cmd.tick) begin
         cd_in = (cd_ff != '0) ? DB'(cd_ff - DB'(1)) : '0;
      end

      if (cmd.pulse) begin
         cd_in          = ramping_ff ? cur_ff : end_ff;
         pulses_left_in = CB'(pulses_left_ff - CB'(1));
         if (ramping_ff) begin
            if (nxt_out) begin
               ramping_in = 1'b0;
            end else begin
               cur_in = DB'(nxt_s);
            end
         end
      end

      if (cmd.finish) begin
         moving_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff  <= 1'b0;
         dir_ff     <= stpramp_pkg::DIR_FWD;
         seg_idx_ff <= stpramp_pkg::SEG_ACCEL;
      end else begin
         moving_ff  <= moving_in;
         dir_ff     <= dir_in;
         seg_idx_ff <= seg_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pulses_left_ff <= pulses_left_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      cur_ff         <= cur_in;
      step_mag_ff    <= step_mag_in;
      step_neg_ff    <= step_neg_in;
      ramping_ff     <= ramping_in;
      cd_ff          <= cd_in;
      cruise_ff      <= cruise_in;
      idle_lat_ff    <= idle_lat_in;
      ramp_len_ff    <= ramp_len_in;
      cruise_len_ff  <= cruise_len_in;
      mag0_ff        <= mag0_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
   end

   assign stat.moving    = moving_ff;
   assign stat.tick_due  = cd_ff <= DB'(1);
   assign stat.seg_empty = pulses_left_ff == '0;
   assign stat.last_seg  = seg_idx_ff >= stpramp_pkg::SEG_DECEL;
   assign stat.div_last  = div_cnt_ff == KB'(DB - 1);
   assign stat.dir       = dir_ff;

endmodule

// ----- hw/rtl/stpramp_ctrl.sv -----
// Sequencing state machine, stream handshakes and result register.
module stpramp_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [stpramp_pkg::ACTION_BITS-1:0]    action,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [stpramp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output stpramp_pkg::dp_cmd_type                cmd,
   input  stpramp_pkg::dp_stat_type               stat
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_EVENT  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      step_ff, step_in;
   logic      done_ff, done_in;
   logic      rej_ff, rej_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [stpramp_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic      accept;
   logic      is_tick;
   logic      out_free;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid & req_tready;
   assign is_tick    = action == stpramp_pkg::ACT_TICK;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      done_in      = done_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = 1'b0;
               done_in = 1'b0;
               rej_in  = 1'b0;
               if (is_tick) begin
                  cmd.tick = stat.moving;
                  state_in = (stat.moving && stat.tick_due) ? ST_EVENT : ST_RESULT;
               end else if (stat.moving) begin
                  rej_in   = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  cmd.start_move = 1'b1;
                  state_in       = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_first = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_EVENT: begin
            // empty segments are skipped one per cycle
            if (stat.seg_empty) begin
               if (stat.last_seg) begin
                  cmd.finish = 1'b1;
                  done_in    = 1'b1;
                  state_in   = ST_RESULT;
               end else begin
                  cmd.load_next = 1'b1;
               end
            end else begin
               cmd.pulse = 1'b1;
               step_in   = 1'b1;
               state_in  = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, rej_ff, done_ff, stat.moving,
                               stat.dir[1], stat.dir[0], step_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      done_ff     <= done_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- test/step_pulse_checker.sv -----
// Watches the ramp generator's channels, predicts each response and compares it.
`timescale 1ns / 1ps

module step_pulse_checker
   import stpramp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending_results,
   output logic                     busy_now
);

   localparam int TGT_LSB = ACTION_BITS;
   localparam int CNT_LSB = ACTION_BITS + DELAY_BITS;

   // same bit order as rsp_tdata[5:0]
   typedef struct packed {
      logic rejected;
      logic done;
      logic busy;
      logic left_dir;
      logic right_dir;
      logic step;
   } pin_result_type;

   pin_result_type expected_pins_q[$];
   pin_result_type want, got;
   int             mismatch_count = 0;

   // register shadows
   logic [DELAY_BITS-1:0] cfg_idle;
   logic [RAMP_BITS-1:0]  cfg_ramp;

   // motion state
   logic                  moving;
   logic [1:0]            seg_idx;
   logic [COUNT_BITS-1:0] seg_left;
   logic [DELAY_BITS-1:0] seg_start, seg_end, cur_delay;
   int                    delay_step;
   logic                  ramping;
   logic [DELAY_BITS-1:0] countdown;
   logic [DELAY_BITS-1:0] cruise_delay;
   logic [1:0]            dir;
   // latched when a move is taken
   logic [DELAY_BITS-1:0] lat_idle;
   logic [COUNT_BITS-1:0] ramp_len, cruise_len;

   assign fail_count = mismatch_count;

   function automatic void flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   function automatic string pins_text(input pin_result_type r);
      return $sformatf("step=%b rdir=%b ldir=%b busy=%b done=%b rej=%b",
                       r.step, r.right_dir, r.left_dir, r.busy, r.done, r.rejected);
   endfunction

   // delay slope of segment k, truncated toward zero, never zero
   function automatic void plan_segment(input logic [1:0] k);
      logic [COUNT_BITS-1:0] n;
      logic [DELAY_BITS-1:0] s, e;
      int                    diff, q;
      n = (k == SEG_CRUISE) ? cruise_len : ramp_len;
      s = (k == SEG_ACCEL) ? lat_idle : cruise_delay;
      e = (k == SEG_DECEL) ? lat_idle : cruise_delay;
      diff = int'(s) - int'(e);
      q = 0;
      if (n != 0) q = diff / int'(n);
      if (q == 0) q = (diff < 0) ? -1 : 1;
      seg_idx    = k;
      seg_left   = n;
      seg_start  = s;
      seg_end    = e;
      cur_delay  = s;
      ramping    = 1'b1;
      delay_step = q;
   endfunction

   // countdown expired: next pulse, or the end of the move
   function automatic void fire_event(output logic pulse, output logic finished);
      int nxt, lo, hi;
      pulse    = 1'b0;
      finished = 1'b0;
      // empty segments are skipped
      while (seg_left == 0) begin
         if (seg_idx >= SEG_DECEL) begin
            moving   = 1'b0;
            finished = 1'b1;
            return;
         end
         plan_segment(seg_idx + 2'd1);
      end
      countdown = ramping ? cur_delay : seg_end;
      seg_left  = seg_left - 1'b1;
      if (ramping) begin
         nxt = int'(cur_delay) - delay_step;
         lo  = (seg_start < seg_end) ? int'(seg_start) : int'(seg_end);
         hi  = (seg_start < seg_end) ? int'(seg_end) : int'(seg_start);
         // past the end delay: hold it for the rest of the segment
         if (nxt < lo || nxt > hi) ramping = 1'b0;
         else cur_delay = DELAY_BITS'(nxt);
      end
      pulse = 1'b1;
   endfunction

   function automatic pin_result_type apply_request(input logic [REQ_DATA_BITS-1:0] data);
      logic [ACTION_BITS-1:0] act;
      logic [DELAY_BITS-1:0]  target;
      logic [COUNT_BITS-1:0]  count;
      logic                   pulse, finished;
      int                     twice;
      pin_result_type         r;
      act    = data[ACTION_BITS-1:0];
      target = data[TGT_LSB +: DELAY_BITS];
      count  = data[CNT_LSB +: COUNT_BITS];
      r = '0;
      if (act != ACT_TICK) begin
         if (moving) begin
            r.rejected = 1'b1;
         end else begin
            case (act)
               ACT_BWD:   dir = DIR_BWD;
               ACT_LEFT:  dir = DIR_LEFT;
               ACT_RIGHT: dir = DIR_RIGHT;
               default:   dir = DIR_FWD;
            endcase
            cruise_delay = target;
            lat_idle     = cfg_idle;
            twice        = int'(cfg_ramp) * 2;
            if (int'(count) < twice) begin
               ramp_len   = count >> 1;
               cruise_len = '0;
            end else begin
               ramp_len   = COUNT_BITS'(cfg_ramp);
               cruise_len = count - COUNT_BITS'(twice);
            end
            plan_segment(SEG_ACCEL);
            countdown = DELAY_BITS'(1);
            moving    = 1'b1;
         end
      end else if (moving) begin
         if (countdown != 0) countdown = countdown - 1'b1;
         if (countdown == 0) begin
            fire_event(pulse, finished);
            r.step = pulse;
            r.done = finished;
         end
      end
      r.right_dir = dir[0];
      r.left_dir  = dir[1];
      r.busy      = moving;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_idle     = BASE_DELAY_RST;
         cfg_ramp     = RAMP_PULSES_RST;
         moving       = 1'b0;
         seg_idx      = SEG_ACCEL;
         seg_left     = '0;
         seg_start    = '0;
         seg_end      = '0;
         cur_delay    = '0;
         delay_step   = 0;
         ramping      = 1'b0;
         countdown    = '0;
         cruise_delay = '0;
         dir          = DIR_FWD;
         lat_idle     = '0;
         ramp_len     = '0;
         cruise_len   = '0;
         expected_pins_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_BITS-1:2] == REG_BASE_DELAY)
                  cfg_idle = csr_pwdata[DELAY_BITS-1:0];
               else
                  cfg_ramp = csr_pwdata[RAMP_BITS-1:0];
            end else begin
               if (csr_prdata !== ((csr_paddr[CSR_ADDR_BITS-1:2] == REG_BASE_DELAY) ?
                                   CSR_DATA_BITS'(cfg_idle) : CSR_DATA_BITS'(cfg_ramp)))
                  flag_mismatch($sformatf("register read at 0x%0h: expected %0d/%0d, got %0d",
                                          csr_paddr, cfg_idle, cfg_ramp, csr_prdata));
            end
         end
         // retire before predicting: a response never belongs to a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            got = pin_result_type'(rsp_tdata[5:0]);
            if (expected_pins_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected response %s", pins_text(got)));
            end else begin
               want = expected_pins_q.pop_front();
               if (got.step !== want.step || got.right_dir !== want.right_dir ||
                   got.left_dir !== want.left_dir || got.busy !== want.busy ||
                   got.done !== want.done || got.rejected !== want.rejected)
                  flag_mismatch($sformatf("expected %s, got %s",
                                          pins_text(want), pins_text(got)));
            end
         end
         if (req_tvalid && req_tready)
            expected_pins_q.push_back(apply_request(req_tdata));
      end
      pending_results = expected_pins_q.size();
      busy_now        = moving;
   end

endmodule

// ----- test/tb_top.sv -----
// Top of the ramp generator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
   import stpramp_pkg::*;

   // spare action codes; the block treats them as a forward move
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;

   // a correct run stays well within this limit even with every gap and stall
   // at its longest
   localparam int CYCLE_LIMIT = 400_000;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int   fail_count;
   int   pending_results;
   logic busy_now;
   int   cycle_count = 0;
   logic calm        = 1'b0;   // no idling on either side once set
   int   ready_left  = 0;

   always #6 clock = ~clock;

   stepper_trapezoid_ramp_generator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   step_pulse_checker pin_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .busy_now        (busy_now)
   );

   // Response side back-pressure: ready drops low now and then, and stays
   // high for longer stretches in between.
   always @(negedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(1, 12);
         end else begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(1, 24);
         end
      end else begin
         ready_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Request transfer. Entered and left at a falling edge; valid stays high on
   // return so a following transfer can go back to back. Anything else that
   // waits must drop valid first (see drain).
   task automatic send_item(input logic [ACTION_BITS-1:0] act,
                            input logic [DELAY_BITS-1:0]  target,
                            input logic [COUNT_BITS-1:0]  count);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({count, target, act});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // ticks carry junk in the unused fields
   task automatic tick_until_stopped();
      while (busy_now)
         send_item(ACT_TICK, DELAY_BITS'($urandom), COUNT_BITS'($urandom));
   endtask

   // hold off the sender until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic reg_index,
                             input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // new profile; often lands in the middle of a move, which keeps its
   // latched values
   task automatic set_profile(input logic [15:0] idle, input logic [15:0] ramp);
      drain();
      csr_access(1'b1, REG_BASE_DELAY, idle);
      csr_access(1'b1, REG_RAMP_PULSES, ramp);
      csr_access(1'b0, REG_BASE_DELAY, '0);
      csr_access(1'b0, REG_RAMP_PULSES, '0);
   endtask

   initial begin
      logic [ACTION_BITS-1:0] act;
      logic [DELAY_BITS-1:0]  target;
      logic [COUNT_BITS-1:0]  count;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset profile: tick while stopped, zero-pulse move ends on first tick,
      // command while busy is refused
      send_item(ACT_TICK, '0, '0);
      send_item(ACT_FWD, 16'd50, '0);
      send_item(ACT_LEFT, 16'hFFFF, 24'hFFFFFF);
      tick_until_stopped();

      // top of both registers; single-pulse move has empty ramps and no cruise
      set_profile(16'hFFFF, 16'hFFFF);
      send_item(ACT_BWD, 16'hFFFF, 24'd1);
      send_item(ACT_RIGHT, 16'hAAAA, 24'h555555);
      tick_until_stopped();

      // zero delays and zero ramp length: all cruise at a delay of zero
      set_profile(16'd0, 16'd0);
      send_item(ACT_LEFT, 16'd0, 24'd5);
      send_item(ACT_SPARE_HI, 16'h5555, 24'hAAAAAA);
      tick_until_stopped();

      // short move with an odd count (one pulse dropped), then one with cruise
      set_profile(16'd2, 16'd3);
      send_item(ACT_SPARE_LO, 16'd9, 24'd5);
      tick_until_stopped();
      send_item(ACT_RIGHT, 16'd1, 24'd12);
      tick_until_stopped();

      // profile change in the middle of a move, then a move on the new one
      send_item(ACT_FWD, 16'd4, 24'd10);
      repeat (3) send_item(ACT_TICK, '0, '0);
      set_profile(16'd7, 16'd1);
      tick_until_stopped();
      send_item(ACT_BWD, 16'd4, 24'd10);
      tick_until_stopped();

      // steep ramp: the whole span from 1 to 40 ticks in a single step each way
      set_profile(16'd1, 16'd1);
      send_item(ACT_FWD, 16'd40, 24'd2);
      tick_until_stopped();

      // --- random ---
      // mostly well-formed moves followed by ticks; some commands land while
      // busy and carry full-width junk
      for (int phase = 0; phase < 8; phase++) begin
         set_profile(DELAY_BITS'($urandom_range(0, 6)), RAMP_BITS'($urandom_range(0, 6)));
         if (phase == 7) calm = 1'b1;
         for (int n = 0; n < 80; n++) begin
            act    = ACT_TICK;
            target = DELAY_BITS'($urandom);
            count  = COUNT_BITS'($urandom);
            if (busy_now) begin
               if ($urandom_range(0, 7) == 0)
                  act = ACTION_BITS'($urandom_range(ACT_FWD, ACT_SPARE_HI));
            end else if ($urandom_range(0, 1) == 0) begin
               act    = ACTION_BITS'($urandom_range(ACT_FWD, ACT_SPARE_HI));
               target = DELAY_BITS'($urandom_range(0, 8));
               count  = ($urandom_range(0, 3) == 0) ? COUNT_BITS'($urandom_range(0, 3))
                                                     : COUNT_BITS'($urandom_range(4, 16));
            end
            send_item(act, target, count);
         end
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
